// File: design/mbt_pkg.sv
`default_nettype none

package mbt_pkg;

    // Field widths of the item and result beats.
    localparam int VALUE_W = 30;
    localparam int COUNT_W = 10;

    // Width of a counter that runs over the bits of one value.
    localparam int STEP_W = $clog2(VALUE_W + 1);

    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [COUNT_W-1:0] count_t;

    // The modulus, the exponent of the Fermat inverse, and the multiplicative one.
    localparam value_t PRIME_MOD = 30'd1000000007;
    localparam value_t PRIME_EXP = PRIME_MOD - 30'd2;
    localparam value_t VALUE_ONE = 30'd1;

    // The top exponent bit is always set, so the power walk starts one bit below it.
    localparam logic [STEP_W-1:0] EXP_TOP = STEP_W'(VALUE_W - 2);

    // Operation code carried by the op field.
    localparam logic OP_PREPARE = 1'b0;

endpackage

`default_nettype wire

// File: design/mbt_ram.sv
`default_nettype none

module mbt_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// File: design/mbt_mulmod.sv
`default_nettype none

module mbt_mulmod (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire mbt_pkg::value_t x,
    input  wire mbt_pkg::value_t y,
    output      logic            done,
    output      mbt_pkg::value_t product
);

    import mbt_pkg::*;

    localparam int SUM_W = VALUE_W + 2;

    // Interleaved modular multiply: one multiplier bit per cycle, MSB first.
    value_t              acc_reg;
    value_t              x_reg;
    value_t              y_reg;
    logic [STEP_W-1:0]   cnt_reg;
    logic                done_reg;

    logic [SUM_W-1:0]    step_sum;
    logic [SUM_W-1:0]    sub_one;
    logic [SUM_W-1:0]    sub_two;
    value_t              step_val;

    // The doubled accumulator plus the addend stays below three times the prime.
    always_comb
    begin
        step_sum = {1'b0, acc_reg, 1'b0}
                 + {2'b00, x_reg & {VALUE_W{y_reg[VALUE_W-1]}}};
        sub_one  = step_sum - {2'b00, PRIME_MOD};
        sub_two  = step_sum - {1'b0, PRIME_MOD, 1'b0};
        if (step_sum >= {1'b0, PRIME_MOD, 1'b0})
        begin
            step_val = sub_two[VALUE_W-1:0];
        end
        else if (step_sum >= {2'b00, PRIME_MOD})
        begin
            step_val = sub_one[VALUE_W-1:0];
        end
        else
        begin
            step_val = step_sum[VALUE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == STEP_W'(1)) && !start;
            if (start)
            begin
                cnt_reg <= STEP_W'(VALUE_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            x_reg   <= x;
            y_reg   <= y;
        end
        else if (cnt_reg != '0)
        begin
            acc_reg <= step_val;
            y_reg   <= {y_reg[VALUE_W-2:0], 1'b0};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

// File: design/modular_binomial_table.sv
// Query: from the accepted beat to the result beat, both tables are read, then two
// modular multiplies run in turn; out-of-range queries go straight to the result beat.
// Prepare to limit L runs its multiplies in the shared multiplier; L = 0 only writes entry zero.
// One item is in work at a time; throughput is bounded by the bit-serial multiplier.
// Reset (rst_n, asynchronous, active low) clears the sequencer, the prepared flag
// and limit, and the result beat; the table memories are not cleared.
`default_nettype none

module modular_binomial_table #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic            clk,
    input  wire logic            rst_n,

    input  wire logic            item_valid,
    output      logic            item_ready,
    input  wire logic            op,
    input  wire mbt_pkg::count_t count,
    input  wire mbt_pkg::count_t choose,

    output      logic            result_valid,
    input  wire logic            result_ready,
    output      mbt_pkg::value_t value,
    output      logic            error
);

    import mbt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    // Sequencer codes. Unless the limit is zero, the prepare walk runs a forward pass for
    // the factorials, one Fermat exponentiation of the largest factorial, and a backward
    // pass that peels one factor off the running inverse per entry.
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_P_INIT  = 4'd1;
    localparam logic [3:0] S_P_FWD   = 4'd2;
    localparam logic [3:0] S_P_FWD_W = 4'd3;
    localparam logic [3:0] S_P_SQ    = 4'd4;
    localparam logic [3:0] S_P_SQ_W  = 4'd5;
    localparam logic [3:0] S_P_ML    = 4'd6;
    localparam logic [3:0] S_P_ML_W  = 4'd7;
    localparam logic [3:0] S_P_BWR   = 4'd8;
    localparam logic [3:0] S_P_BMUL  = 4'd9;
    localparam logic [3:0] S_P_BW    = 4'd10;
    localparam logic [3:0] S_Q_RD1   = 4'd11;
    localparam logic [3:0] S_Q_RD2   = 4'd12;
    localparam logic [3:0] S_Q_W1    = 4'd13;
    localparam logic [3:0] S_Q_W2    = 4'd14;
    localparam logic [3:0] S_OUT     = 4'd15;

    logic [3:0]        state_reg, state_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [AW-1:0]     lim_reg, lim_next;
    logic [AW-1:0]     limit_reg, limit_next;
    logic              prepared_reg, prepared_next;
    value_t            run_reg, run_next;
    value_t            acc_reg, acc_next;
    logic [STEP_W-1:0] ebit_reg, ebit_next;
    logic [AW-1:0]     qa_reg, qa_next;
    logic [AW-1:0]     qb_reg, qb_next;
    logic [AW-1:0]     qd_reg, qd_next;
    value_t            res_value_reg, res_value_next;
    logic              res_error_reg, res_error_next;
    logic              result_valid_reg, result_valid_next;
    value_t            value_reg, value_next;
    logic              error_reg, error_next;

    // Shared multiplier hookup.
    logic              mul_start;
    value_t            mul_x;
    value_t            mul_y;
    logic              mul_done;
    value_t            mul_product;

    // Table memory ports.
    logic              fact_we, fact_re;
    logic [AW-1:0]     fact_waddr, fact_raddr;
    value_t            fact_wdata, fact_rdata;
    logic              inv_we, inv_re;
    logic [AW-1:0]     inv_waddr, inv_raddr;
    value_t            inv_wdata, inv_rdata;

    // Decoded beat fields.
    logic [31:0]       count_ext;
    logic [31:0]       choose_ext;
    logic [31:0]       lim_calc;
    logic [31:0]       diff_calc;
    logic              query_err;

    mbt_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .x       (mul_x),
        .y       (mul_y),
        .done    (mul_done),
        .product (mul_product)
    );

    mbt_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_fact_ram (
        .clk   (clk),
        .we    (fact_we),
        .waddr (fact_waddr),
        .wdata (fact_wdata),
        .re    (fact_re),
        .raddr (fact_raddr),
        .rdata (fact_rdata)
    );

    mbt_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_inv_ram (
        .clk   (clk),
        .we    (inv_we),
        .waddr (inv_waddr),
        .wdata (inv_wdata),
        .re    (inv_re),
        .raddr (inv_raddr),
        .rdata (inv_rdata)
    );

    // A prepare limit past the table saturates to the last entry. A query is
    // refused when nothing is prepared, when b exceeds a, or when a lies past
    // the prepared limit; the refused result leaves the tables untouched.
    always_comb
    begin
        count_ext  = 32'(count);
        choose_ext = 32'(choose);
        lim_calc   = (count_ext > 32'(TABLE_DEPTH - 1)) ? 32'(TABLE_DEPTH - 1) : count_ext;
        diff_calc  = count_ext - choose_ext;
        query_err  = !prepared_reg || (choose_ext > count_ext)
                  || (count_ext > 32'(limit_reg)) || (count_ext >= 32'(TABLE_DEPTH));
    end

    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        lim_next          = lim_reg;
        limit_next        = limit_reg;
        prepared_next     = prepared_reg;
        run_next          = run_reg;
        acc_next          = acc_reg;
        ebit_next         = ebit_reg;
        qa_next           = qa_reg;
        qb_next           = qb_reg;
        qd_next           = qd_reg;
        res_value_next    = res_value_reg;
        res_error_next    = res_error_reg;
        value_next        = value_reg;
        error_next        = error_reg;
        result_valid_next = result_valid_reg && !result_ready;

        mul_start  = 1'b0;
        mul_x      = acc_reg;
        mul_y      = acc_reg;

        fact_we    = 1'b0;
        fact_waddr = idx_reg;
        fact_wdata = mul_product;
        fact_re    = 1'b0;
        fact_raddr = qa_reg;
        inv_we     = 1'b0;
        inv_waddr  = idx_reg;
        inv_wdata  = mul_product;
        inv_re     = 1'b0;
        inv_raddr  = qb_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (op == OP_PREPARE)
                    begin
                        lim_next   = lim_calc[AW-1:0];
                        state_next = S_P_INIT;
                    end
                    else if (query_err)
                    begin
                        res_value_next = '0;
                        res_error_next = 1'b1;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        qa_next    = count_ext[AW-1:0];
                        qb_next    = choose_ext[AW-1:0];
                        qd_next    = diff_calc[AW-1:0];
                        state_next = S_Q_RD1;
                    end
                end
            end

            // Entry zero of both tables is one.
            S_P_INIT:
            begin
                fact_we    = 1'b1;
                fact_waddr = '0;
                fact_wdata = VALUE_ONE;
                inv_we     = 1'b1;
                inv_waddr  = '0;
                inv_wdata  = VALUE_ONE;
                run_next   = VALUE_ONE;
                idx_next   = AW'(1);
                if (lim_reg == '0)
                begin
                    limit_next     = lim_reg;
                    prepared_next  = 1'b1;
                    res_value_next = '0;
                    res_error_next = 1'b0;
                    state_next     = S_OUT;
                end
                else
                begin
                    state_next = S_P_FWD;
                end
            end

            S_P_FWD:
            begin
                mul_start  = 1'b1;
                mul_x      = run_reg;
                mul_y      = VALUE_W'(idx_reg);
                state_next = S_P_FWD_W;
            end

            S_P_FWD_W:
            begin
                if (mul_done)
                begin
                    run_next = mul_product;
                    fact_we  = 1'b1;
                    if (idx_reg == lim_reg)
                    begin
                        acc_next   = mul_product;
                        ebit_next  = EXP_TOP;
                        state_next = S_P_SQ;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = S_P_FWD;
                    end
                end
            end

            // Left-to-right square-and-multiply; run_reg holds the base.
            S_P_SQ:
            begin
                mul_start  = 1'b1;
                state_next = S_P_SQ_W;
            end

            S_P_SQ_W:
            begin
                if (mul_done)
                begin
                    acc_next = mul_product;
                    if (PRIME_EXP[ebit_reg])
                    begin
                        state_next = S_P_ML;
                    end
                    else if (ebit_reg == '0)
                    begin
                        state_next = S_P_BWR;
                    end
                    else
                    begin
                        ebit_next  = ebit_reg - STEP_W'(1);
                        state_next = S_P_SQ;
                    end
                end
            end

            S_P_ML:
            begin
                mul_start  = 1'b1;
                mul_y      = run_reg;
                state_next = S_P_ML_W;
            end

            S_P_ML_W:
            begin
                if (mul_done)
                begin
                    acc_next = mul_product;
                    if (ebit_reg == '0)
                    begin
                        state_next = S_P_BWR;
                    end
                    else
                    begin
                        ebit_next  = ebit_reg - STEP_W'(1);
                        state_next = S_P_SQ;
                    end
                end
            end

            // acc_reg now holds the inverse of the largest factorial.
            S_P_BWR:
            begin
                inv_we     = 1'b1;
                inv_wdata  = acc_reg;
                state_next = S_P_BMUL;
            end

            S_P_BMUL:
            begin
                mul_start  = 1'b1;
                mul_y      = VALUE_W'(idx_reg);
                state_next = S_P_BW;
            end

            S_P_BW:
            begin
                if (mul_done)
                begin
                    acc_next  = mul_product;
                    inv_we    = 1'b1;
                    inv_waddr = idx_reg - AW'(1);
                    idx_next  = idx_reg - AW'(1);
                    if (idx_reg == AW'(1))
                    begin
                        limit_next     = lim_reg;
                        prepared_next  = 1'b1;
                        res_value_next = '0;
                        res_error_next = 1'b0;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        state_next = S_P_BMUL;
                    end
                end
            end

            S_Q_RD1:
            begin
                fact_re    = 1'b1;
                inv_re     = 1'b1;
                state_next = S_Q_RD2;
            end

            // The third read lands while the first multiply runs and is held
            // in the memory's read register until the second multiply starts.
            S_Q_RD2:
            begin
                mul_start  = 1'b1;
                mul_x      = fact_rdata;
                mul_y      = inv_rdata;
                inv_re     = 1'b1;
                inv_raddr  = qd_reg;
                state_next = S_Q_W1;
            end

            S_Q_W1:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_x      = mul_product;
                    mul_y      = inv_rdata;
                    state_next = S_Q_W2;
                end
            end

            S_Q_W2:
            begin
                if (mul_done)
                begin
                    res_value_next = mul_product;
                    res_error_next = 1'b0;
                    state_next     = S_OUT;
                end
            end

            // Hand the result to the output register as soon as it is free.
            S_OUT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_next = 1'b1;
                    value_next        = res_value_reg;
                    error_next        = res_error_reg;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            limit_reg        <= '0;
            prepared_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            limit_reg        <= limit_next;
            prepared_reg     <= prepared_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        lim_reg       <= lim_next;
        run_reg       <= run_next;
        acc_reg       <= acc_next;
        ebit_reg      <= ebit_next;
        qa_reg        <= qa_next;
        qb_reg        <= qb_next;
        qd_reg        <= qd_next;
        res_value_reg <= res_value_next;
        res_error_reg <= res_error_next;
        value_reg     <= value_next;
        error_reg     <= error_next;
    end

    // A new beat is taken only while the sequencer is idle; the output
    // register lets it be taken while the previous result beat still waits.
    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign value        = value_reg;
    assign error        = error_reg;

    // The multiplier finishes only while the sequencer waits on it.
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == S_P_FWD_W || state_reg == S_P_SQ_W
                   || state_reg == S_P_ML_W || state_reg == S_P_BW
                   || state_reg == S_Q_W1 || state_reg == S_Q_W2))
        else $error("multiplier finished outside a wait state");

    // Table reads for a query happen only after a prepare.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_Q_RD1) |-> prepared_reg)
        else $error("query reached the tables before any prepare");

    // Every delivered value is reduced below the prime.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (value < PRIME_MOD))
        else $error("result value not reduced");

    // A refused query carries a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && error) |-> (value == '0))
        else $error("error result with nonzero value");

endmodule

`default_nettype wire
